// File: src/pcbp_pkg.sv
// Shared types and constants for the prefix code bit packer.
package pcbp_pkg;

  localparam logic [7:0]  SYM_END   = 8'd0;
  localparam logic [7:0]  SYM_A     = 8'd97;
  localparam logic [7:0]  SYM_Z     = 8'd122;
  localparam logic [4:0]  OFS_C     = 5'd2;
  localparam logic [4:0]  GRP2      = 5'd6;
  localparam logic [4:0]  GRP3      = 5'd14;
  localparam logic [4:0]  GRP4      = 5'd26;
  localparam logic [15:0] TOTAL_MAX = 16'hFFFF;
  localparam logic [3:0]  BYTE_BITS = 4'd8;
  localparam int          QDEPTH_DEF = 4;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic       is_end;
    logic [5:0] code;
    logic [2:0] len;
  } op_t;

endpackage

// File: src/pcbp_front.sv
// Front end: takes characters, forms prefix codes and drops non-letters other than end-of-text.
module pcbp_front (
  input  logic             in_push,
  input  logic [7:0]       in_symbol,
  output logic             op_push,
  output pcbp_pkg::op_t    op
);
  import pcbp_pkg::*;

  logic       is_letter;
  logic       is_end;
  logic [4:0] idx;
  logic [1:0] grp;
  logic [3:0] sub;

  assign is_end    = (in_symbol == SYM_END);
  assign is_letter = (in_symbol >= SYM_A) && (in_symbol <= SYM_Z);
  assign idx       = 5'(in_symbol - SYM_A);

  always_comb begin
    if (idx < OFS_C) begin
      grp = 2'd0;
      sub = 4'(idx);
    end else if (idx < GRP2) begin
      grp = 2'd1;
      sub = 4'(idx - OFS_C);
    end else if (idx < GRP3) begin
      grp = 2'd2;
      sub = 4'(idx - GRP2);
    end else begin
      grp = 2'd3;
      sub = 4'(idx - GRP3);
    end
  end

  assign op_push   = in_push && (is_letter || is_end);
  assign op.is_end = is_end;
  assign op.code   = {sub, grp};
  assign op.len    = 3'd3 + {1'b0, grp};

endmodule

// File: src/pcbp_queue.sv
// Short queue of classified items between front and back.
module pcbp_queue #(
  parameter int QDEPTH = pcbp_pkg::QDEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  pcbp_pkg::op_t    wr_op,
  input  logic             rd_en,
  output pcbp_pkg::op_t    rd_op,
  output logic             q_full,
  output logic             q_empty
);
  import pcbp_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  op_t           mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

// File: src/pcbp_back.sv
// Back end: packs code bits into bytes and holds the result register.
module pcbp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  pcbp_pkg::op_t    q_op,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_packed_byte,
  output logic [3:0]       out_valid_bits,
  output logic             out_final_flag,
  output logic [15:0]      out_total_bits
);
  import pcbp_pkg::*;

  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [15:0] total_r, total_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  vbits_r, vbits_nxt;
  logic        final_r, final_nxt;
  logic [15:0] otot_r, otot_nxt;

  logic [13:0] acc;
  logic [3:0]  cnt;
  logic [16:0] sum;
  logic [15:0] sat_total;
  logic        emits;
  logic        slot_free;

  assign acc       = {7'd0, pend_bits_r} | ({8'd0, q_op.code} << pend_cnt_r);
  assign cnt       = {1'b0, pend_cnt_r} + {1'b0, q_op.len};
  assign sum       = {1'b0, total_r} + {14'd0, q_op.len};
  assign sat_total = sum[16] ? TOTAL_MAX : sum[15:0];
  assign emits     = q_op.is_end || (cnt >= BYTE_BITS);
  assign slot_free = !out_vld_r || pop;
  assign q_pop     = !q_empty && (!emits || slot_free);

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    total_nxt     = total_r;
    out_vld_nxt   = out_vld_r && !pop;
    byte_nxt      = byte_r;
    vbits_nxt     = vbits_r;
    final_nxt     = final_r;
    otot_nxt      = otot_r;
    if (q_pop) begin
      if (q_op.is_end) begin
        out_vld_nxt   = 1'b1;
        byte_nxt      = {1'b0, pend_bits_r};
        vbits_nxt     = {1'b0, pend_cnt_r};
        final_nxt     = 1'b1;
        otot_nxt      = total_r;
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
        total_nxt     = '0;
      end else if (cnt >= BYTE_BITS) begin
        out_vld_nxt   = 1'b1;
        byte_nxt      = acc[7:0];
        vbits_nxt     = BYTE_BITS;
        final_nxt     = 1'b0;
        otot_nxt      = sat_total;
        pend_bits_nxt = {1'b0, acc[13:8]};
        pend_cnt_nxt  = 3'(cnt - BYTE_BITS);
        total_nxt     = sat_total;
      end else begin
        pend_bits_nxt = acc[6:0];
        pend_cnt_nxt  = cnt[2:0];
        total_nxt     = sat_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      total_r     <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      total_r     <= total_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    vbits_r <= vbits_nxt;
    final_r <= final_nxt;
    otot_r  <= otot_nxt;
  end

  assign empty           = !out_vld_r;
  assign out_packed_byte = byte_r;
  assign out_valid_bits  = vbits_r;
  assign out_final_flag  = final_r;
  assign out_total_bits  = otot_r;

endmodule

// File: src/prefix_code_bit_packer.sv
// Top level of the prefix code bit packer: front end, item queue and packer.
//
// For each accepted character, the front end turns a letter a-z
// into a 3- to 6-bit prefix code (two group bits, then the index within the
// group), drops any other non-zero character at once, and passes letters and
// the zero end-of-text character into a short queue of QDEPTH entries. The
// packer takes one queued item per cycle while the result register has room
// for any result it makes, appends its bits least significant first, and
// places every completed byte in the result register together with the
// running bit count (saturating at 65535). The end-of-text character yields
// one final transaction carrying the partial byte (unused bits zero), its
// bit count and the total, then clears the packer. A result reaches the
// out_ ports through the queue write and then the packer step, and stays
// there until popped; throughput is one character per cycle as long as
// results are popped, and the queue absorbs up to QDEPTH characters of
// back-pressure before full rises.
module prefix_code_bit_packer #(
  parameter int QDEPTH = pcbp_pkg::QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_symbol,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_packed_byte,
  output logic [3:0]  out_valid_bits,
  output logic        out_final_flag,
  output logic [15:0] out_total_bits
);
  import pcbp_pkg::*;

  logic op_push;
  op_t  op_in;
  op_t  op_out;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // Classify the character; non-letters other than end-of-text vanish here.
  pcbp_front u_front (
    .in_push   (push && !q_full),
    .in_symbol (in_symbol),
    .op_push   (op_push),
    .op        (op_in)
  );

  // Decouple the classifier from the packer.
  pcbp_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (op_push),
    .wr_op   (op_in),
    .rd_en   (q_pop),
    .rd_op   (op_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Pack bits and hold the pending result.
  pcbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_op            (op_out),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_packed_byte (out_packed_byte),
    .out_valid_bits  (out_valid_bits),
    .out_final_flag  (out_final_flag),
    .out_total_bits  (out_total_bits)
  );

  assign full = q_full;

endmodule
